FILE: src/assert_macros.svh
// assertion macros included by the attitude filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

FILE: src/tac_pkg.sv
// shared constants and helpers for the two-axis attitude filter
`default_nettype none

package tac_pkg;

    localparam int TABLE_LEN   = 24;
    localparam int TABLE_IDX_W = 5;
    localparam int TABLE_FRAC  = 30;

    localparam logic [1:0] REG_GAIN_ROLL  = 2'd0;
    localparam logic [1:0] REG_GAIN_PITCH = 2'd1;
    localparam logic [1:0] REG_AZ_MIN     = 2'd2;
    localparam logic [1:0] REG_TILT_LIMIT = 2'd3;

    localparam logic OP_INIT   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // arctangent of 2^-i, 30 fraction bits
    localparam logic [30:0] ATAN_TABLE [TABLE_LEN] = '{
        31'd843314857, 31'd497837830, 31'd263043837, 31'd133525159,
        31'd67021687,  31'd33543516,  31'd16775851,  31'd8388437,
        31'd4194283,   31'd2097149,   31'd1048576,   31'd524288,
        31'd262144,    31'd131072,    31'd65536,     31'd32768,
        31'd16384,     31'd8192,      31'd4096,      31'd2048,
        31'd1024,      31'd512,       31'd256,       31'd128
    };

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [15:0] sat16(input logic signed [31:0] v);
        logic [15:0] r;
        if (v > 32'sd32767)
            r = 16'h7fff;
        else if (v < -32'sd32768)
            r = 16'h8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/two_axis_complementary_attitude.sv
// two-axis second-order complementary attitude filter with cordic atan2
// init loads the angles and integrators and goes straight to the output; update
// runs setup, the cordic loop, the error and the gain multiply steps per axis, roll
// then pitch; an axis with a bypassed accel reference skips the cordic loop
// a new item is accepted only when idle, once the last result is in the output register
// reset clears registers to their defaults and angles and integrators to zero
`default_nettype none

module two_axis_complementary_attitude #(
    parameter int ANGLE_FRAC_BITS   = 12,
    parameter int CORDIC_ITERATIONS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // gyro_roll, gyro_pitch, accel_x, accel_y, accel_z, time_step
    input  wire logic [95:0] s_tdata,
    // op
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // roll_angle, pitch_angle
    output logic [31:0]      m_tdata,
    input  wire logic        wr_en,
    input  wire logic [1:0]  wr_index,
    input  wire logic [14:0] wr_data
);

    localparam int STATE_FRAC = ANGLE_FRAC_BITS + 12;
    localparam int STEP_SHIFT = tac_pkg::TABLE_FRAC - STATE_FRAC;
    localparam int ITER_USED  = (CORDIC_ITERATIONS < tac_pkg::TABLE_LEN) ?
                                CORDIC_ITERATIONS : tac_pkg::TABLE_LEN;
    localparam logic [tac_pkg::TABLE_IDX_W-1:0] ITER_LAST =
        tac_pkg::TABLE_IDX_W'(ITER_USED - 1);
    localparam logic [31:0] STEP_HALF = 32'd1 << (STEP_SHIFT - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_CORD, S_ERR, S_KK, S_E1, S_E2, S_E3, S_E4, S_E5,
        S_E6, S_OUT
    } state_t;

    state_t state_reg;

    logic [14:0] gain_roll_reg, gain_pitch_reg, az_min_reg, tilt_reg;

    logic signed [15:0] gyro_reg [2];
    logic signed [15:0] acc_reg  [2];
    logic signed [15:0] az_reg;
    logic [15:0]        dt_reg;

    logic signed [31:0] est_reg   [2];
    logic signed [31:0] integ_reg [2];
    logic               axis_reg;

    logic signed [33:0] x_reg, y_reg;
    logic signed [31:0] ang_reg;
    logic [tac_pkg::TABLE_IDX_W-1:0] cnt_reg;
    logic signed [32:0] err_reg;
    logic signed [39:0] x2_reg;
    logic signed [71:0] prod_reg;
    logic               m_tvalid_reg;
    logic [31:0]        m_tdata_reg;

    logic [14:0]        k;
    logic signed [31:0] est_cur, integ_cur;
    logic signed [32:0] lim;
    logic               bypass;
    logic signed [33:0] xs, ys;
    logic [31:0]        step;
    logic signed [39:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [71:0] prod_next;
    logic signed [39:0] gyro_st;
    logic signed [39:0] x2_next;
    logic               accept;
    logic               out_load;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    assign k         = axis_reg ? gain_pitch_reg : gain_roll_reg;
    assign est_cur   = est_reg[axis_reg];
    assign integ_cur = integ_reg[axis_reg];
    assign lim       = $signed({1'b0, 32'(tilt_reg) << ANGLE_FRAC_BITS});
    assign bypass    = ($signed({az_reg[15], az_reg}) < $signed({2'b00, az_min_reg}))
                       || (33'(est_cur) > lim) || (33'(est_cur) < -lim);

    assign xs   = x_reg >>> cnt_reg;
    assign ys   = y_reg >>> cnt_reg;
    assign step = (32'(tac_pkg::ATAN_TABLE[cnt_reg]) + STEP_HALF) >> STEP_SHIFT;

    assign gyro_st = $signed({{(24 - ANGLE_FRAC_BITS){gyro_reg[axis_reg][15]}},
                              gyro_reg[axis_reg], {ANGLE_FRAC_BITS{1'b0}}});
    assign x2_next = 40'(integ_cur) + 40'($signed(prod_reg[71:12])) + gyro_st;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_KK:
            begin
                mul_a = $signed({25'd0, k});
                mul_b = $signed({17'd0, k});
            end
            S_E1:
            begin
                mul_a = 40'(err_reg);
                mul_b = $signed({2'b00, prod_reg[29:0]});
            end
            S_E2:
            begin
                mul_a = prod_reg[63:24];
                mul_b = $signed({16'd0, dt_reg});
            end
            S_E3:
            begin
                mul_a = 40'(err_reg);
                mul_b = $signed({16'd0, k, 1'b0});
            end
            S_E5:
            begin
                mul_a = x2_reg;
                mul_b = $signed({16'd0, dt_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = 72'(mul_a) * 72'(mul_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            gain_roll_reg  <= 15'd4096;
            gain_pitch_reg <= 15'd4096;
            az_min_reg     <= 15'd36;
            tilt_reg       <= 15'd6434;
            est_reg[0]     <= '0;
            est_reg[1]     <= '0;
            integ_reg[0]   <= '0;
            integ_reg[1]   <= '0;
            axis_reg       <= 1'b0;
            cnt_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    tac_pkg::REG_GAIN_ROLL:  gain_roll_reg  <= wr_data;
                    tac_pkg::REG_GAIN_PITCH: gain_pitch_reg <= wr_data;
                    tac_pkg::REG_AZ_MIN:     az_min_reg     <= wr_data;
                    tac_pkg::REG_TILT_LIMIT: tilt_reg       <= wr_data;
                    default:                 gain_roll_reg  <= gain_roll_reg;
                endcase
            end
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;
            prod_reg <= prod_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        gyro_reg[0] <= s_tdata[15:0];
                        gyro_reg[1] <= s_tdata[31:16];
                        acc_reg[0]  <= s_tdata[47:32];
                        acc_reg[1]  <= s_tdata[63:48];
                        az_reg      <= s_tdata[79:64];
                        dt_reg      <= s_tdata[95:80];
                        axis_reg    <= 1'b0;
                        if (s_tuser == tac_pkg::OP_INIT)
                        begin
                            est_reg[0]   <= tac_pkg::sat32(64'($signed(s_tdata[47:32]))
                                                           <<< ANGLE_FRAC_BITS);
                            est_reg[1]   <= tac_pkg::sat32(64'($signed(s_tdata[63:48]))
                                                           <<< ANGLE_FRAC_BITS);
                            integ_reg[0] <= tac_pkg::sat32(-(64'($signed(s_tdata[15:0]))
                                                           <<< ANGLE_FRAC_BITS));
                            integ_reg[1] <= tac_pkg::sat32(-(64'($signed(s_tdata[31:16]))
                                                           <<< ANGLE_FRAC_BITS));
                            state_reg    <= S_OUT;
                        end
                        else
                            state_reg <= S_SETUP;
                    end
                end
                S_SETUP:
                begin
                    x_reg   <= $signed({{4{az_reg[15]}}, az_reg, 14'd0});
                    y_reg   <= $signed({{4{acc_reg[axis_reg][15]}}, acc_reg[axis_reg],
                                        14'd0});
                    ang_reg <= '0;
                    cnt_reg <= '0;
                    if (bypass)
                    begin
                        err_reg   <= '0;
                        state_reg <= S_KK;
                    end
                    else
                        state_reg <= S_CORD;
                end
                S_CORD:
                begin
                    if (y_reg > 0)
                    begin
                        x_reg   <= x_reg + ys;
                        y_reg   <= y_reg - xs;
                        ang_reg <= ang_reg + $signed(step);
                    end
                    else if (y_reg < 0)
                    begin
                        x_reg   <= x_reg - ys;
                        y_reg   <= y_reg + xs;
                        ang_reg <= ang_reg - $signed(step);
                    end
                    if (cnt_reg == ITER_LAST)
                        state_reg <= S_ERR;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                S_ERR:
                begin
                    err_reg   <= 33'(ang_reg) - 33'(est_cur);
                    state_reg <= S_KK;
                end
                S_KK: state_reg <= S_E1;
                S_E1: state_reg <= S_E2;
                S_E2: state_reg <= S_E3;
                S_E3:
                begin
                    integ_reg[axis_reg] <= tac_pkg::sat32(64'($signed(prod_reg[71:16]))
                                                          + 64'(integ_cur));
                    state_reg <= S_E4;
                end
                S_E4:
                begin
                    x2_reg    <= x2_next;
                    state_reg <= S_E5;
                end
                S_E5: state_reg <= S_E6;
                S_E6:
                begin
                    est_reg[axis_reg] <= tac_pkg::sat32(64'($signed(prod_reg[71:16]))
                                                        + 64'(est_cur));
                    if (axis_reg)
                        state_reg <= S_OUT;
                    else
                    begin
                        axis_reg  <= 1'b1;
                        state_reg <= S_SETUP;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        m_tdata_reg  <= {tac_pkg::sat16(est_reg[1] >>> ANGLE_FRAC_BITS),
                                         tac_pkg::sat16(est_reg[0] >>> ANGLE_FRAC_BITS)};
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`include "assert_macros.svh"

    `ASSERT_AT(a_busy_after_accept, clk, rst_n, accept |=> (state_reg != S_IDLE), "idle after accept")
    `ASSERT_AT(a_cnt_range, clk, rst_n, (state_reg == S_CORD) |-> (cnt_reg <= ITER_LAST), "cordic count overrun")
    `ASSERT_AT(a_out_from_seq, clk, rst_n, $rose(m_tvalid_reg) |-> ($past(state_reg) == S_OUT), "result without sequence end")
    `ASSERT_NEVER(a_axis_idle, clk, rst_n, (state_reg == S_OUT) && !axis_reg && ($past(state_reg) == S_E6), "pitch axis skipped")

endmodule

`default_nettype wire

FILE: sim/tb.sv
// testbench for the two-axis complementary attitude filter: scoreboard class, drivers, checks
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS  = 12;
    localparam int ROTATIONS  = 16;
    localparam int HOLD_OFF   = 300;
    localparam int DRAIN_WAIT = 60;
    localparam int STALL_MAX  = 3000;

    class attitude_scoreboard;
        logic [14:0] gain_roll, gain_pitch, az_floor, tilt_lim;
        longint      roll_est, pitch_est, roll_int, pitch_int;
        logic [31:0] angle_q[$];
        int          errors;

        function new();
            gain_roll  = 15'd4096;
            gain_pitch = 15'd4096;
            az_floor   = 15'd36;
            tilt_lim   = 15'd6434;
            roll_est   = 0;
            pitch_est  = 0;
            roll_int   = 0;
            pitch_int  = 0;
            errors     = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [14:0] v);
            case (idx)
                tac_pkg::REG_GAIN_ROLL:  gain_roll  = v;
                tac_pkg::REG_GAIN_PITCH: gain_pitch = v;
                tac_pkg::REG_AZ_MIN:     az_floor   = v;
                tac_pkg::REG_TILT_LIMIT: tilt_lim   = v;
                default: ;
            endcase
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function longint vector_angle(longint a, longint z);
            longint x, y, ang, step, xs, ys;
            x = z * 16384;
            y = a * 16384;
            ang = 0;
            for (int i = 0; i < ROTATIONS; i++)
            begin
                step = (longint'(tac_pkg::ATAN_TABLE[i]) + 32) >>> 6;
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    ang = ang + step;
                end
                else if (y < 0)
                begin
                    x = x - ys;
                    y = y + xs;
                    ang = ang - step;
                end
            end
            return ang;
        endfunction

        function void axis_step(inout longint est, inout longint integ, input longint gyro,
                                input longint acc, input longint az, input logic [14:0] k,
                                input longint dt);
            longint lim, refv, err, x1, x2, kk;
            lim = longint'(tilt_lim) <<< FRAC_BITS;
            kk  = longint'(k);
            if (az < longint'(az_floor) || est > lim || est < -lim)
                refv = est;
            else
                refv = vector_angle(acc, az);
            err = refv - est;
            x1 = (err * (kk * kk)) >>> 24;
            integ = clamp32(integ + ((x1 * dt) >>> 16));
            x2 = integ + ((err * 2 * kk) >>> 12) + (gyro <<< FRAC_BITS);
            est = clamp32(est + ((x2 * dt) >>> 16));
        endfunction

        function logic [15:0] to_angle(longint st);
            longint v;
            v = st >>> FRAC_BITS;
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            return v[15:0];
        endfunction

        function void note_input(logic op, logic [95:0] d);
            longint gr, gp, ax, ay, az, dt;
            gr = longint'($signed(d[15:0]));
            gp = longint'($signed(d[31:16]));
            ax = longint'($signed(d[47:32]));
            ay = longint'($signed(d[63:48]));
            az = longint'($signed(d[79:64]));
            dt = longint'(d[95:80]);
            if (op == tac_pkg::OP_INIT)
            begin
                roll_est  = clamp32(ax <<< FRAC_BITS);
                pitch_est = clamp32(ay <<< FRAC_BITS);
                roll_int  = clamp32(-(gr <<< FRAC_BITS));
                pitch_int = clamp32(-(gp <<< FRAC_BITS));
            end
            else
            begin
                axis_step(roll_est, roll_int, gr, ax, az, gain_roll, dt);
                axis_step(pitch_est, pitch_int, gp, ay, az, gain_pitch, dt);
            end
            angle_q.push_back({to_angle(pitch_est), to_angle(roll_est)});
        endfunction

        function void check_result(logic [31:0] d);
            logic [31:0] want;
            if (angle_q.size() == 0)
            begin
                $error("unexpected result transfer %h", d);
                errors++;
                return;
            end
            want = angle_q.pop_front();
            if (d[15:0] !== want[15:0])
            begin
                $error("roll_angle expected %h actual %h", want[15:0], d[15:0]);
                errors++;
            end
            if (d[31:16] !== want[31:16])
            begin
                $error("pitch_angle expected %h actual %h", want[31:16], d[31:16]);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        wr_en = 1'b0;
    logic [1:0]  wr_index = '0;
    logic [14:0] wr_data = '0;

    attitude_scoreboard sb = new();
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    int stall_count = 0;

    two_axis_complementary_attitude u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_input(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_count <= 0;
            else
                stall_count <= stall_count + 1;
            if (stall_count >= STALL_MAX)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // receiver side
    initial
    begin
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic send_item(logic op, logic [15:0] gr, logic [15:0] gp, logic [15:0] ax,
                             logic [15:0] ay, logic [15:0] az, logic [15:0] dt);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {dt, az, ay, ax, gp, gr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.angle_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [14:0] v);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= v;
        @(posedge clk);
        wr_en <= 1'b0;
        sb.write_reg(idx, v);
        @(posedge clk);
    endtask

    task automatic set_regs(logic [14:0] gr, logic [14:0] gp, logic [14:0] azm,
                            logic [14:0] tl);
        write_reg(tac_pkg::REG_GAIN_ROLL, gr);
        write_reg(tac_pkg::REG_GAIN_PITCH, gp);
        write_reg(tac_pkg::REG_AZ_MIN, azm);
        write_reg(tac_pkg::REG_TILT_LIMIT, tl);
    endtask

    function automatic logic [15:0] near(int span);
        return 16'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic send_random();
        logic op;
        op = ($urandom_range(0, 19) == 0) ? tac_pkg::OP_INIT : tac_pkg::OP_UPDATE;
        if ($urandom_range(0, 4) == 0)
            send_item(op, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom));
        else
            send_item(op, near(4096), near(4096), near(8192), near(8192),
                      16'($urandom_range(0, 9000) - 800), 16'($urandom_range(0, 2000)));
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, init and update, degenerate vectors
        send_item(tac_pkg::OP_INIT, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'hffff);
        send_item(tac_pkg::OP_UPDATE, 16'h7fff, 16'h8000, 16'h0000, 16'h0000, 16'h0000,
                  16'hffff);
        send_item(tac_pkg::OP_INIT, 16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(tac_pkg::OP_UPDATE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  16'h0041);
        send_item(tac_pkg::OP_UPDATE, 16'h0000, 16'h0000, 16'h1000, 16'hf000, 16'h0000,
                  16'h0041);
        send_item(tac_pkg::OP_UPDATE, 16'h0100, 16'hff00, 16'h1000, 16'h1000, 16'h0023,
                  16'h0041);
        send_item(tac_pkg::OP_UPDATE, 16'h0100, 16'hff00, 16'h1000, 16'h1000, 16'h0024,
                  16'h0041);
        send_item(tac_pkg::OP_UPDATE, 16'h0000, 16'h0000, 16'h7fff, 16'h8000, 16'h0001,
                  16'hffff);
        send_item(tac_pkg::OP_UPDATE, 16'h0000, 16'h0000, 16'h0800, 16'hf800, 16'h8000,
                  16'h0041);
        send_item(tac_pkg::OP_UPDATE, 16'h0000, 16'h0000, 16'h0800, 16'hf800, 16'h1000,
                  16'h0000);
        send_item(tac_pkg::OP_INIT, 16'h0000, 16'h0000, 16'h1922, 16'he6de, 16'h1000, 16'h0000);
        send_item(tac_pkg::OP_UPDATE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h1000,
                  16'h0100);
        send_item(tac_pkg::OP_INIT, 16'h0000, 16'h0000, 16'h1923, 16'he6dd, 16'h1000, 16'h0000);
        send_item(tac_pkg::OP_UPDATE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h1000,
                  16'h0100);
        send_item(tac_pkg::OP_UPDATE, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                  16'hffff);
        send_item(tac_pkg::OP_UPDATE, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff,
                  16'hffff);

        for (int i = 0; i < 120; i++)
        begin
            if (i == 30)
                hold_req = 1'b1;
            send_random();
        end
        drain();

        set_regs(15'd0, 15'd0, 15'd0, 15'd0);
        for (int i = 0; i < 100; i++)
            send_random();
        drain();

        set_regs(15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff);
        for (int i = 0; i < 100; i++)
            send_random();
        drain();

        set_regs(15'd8192, 15'd2048, 15'd0, 15'h7fff);
        for (int i = 0; i < 100; i++)
            send_random();
        drain();

        set_regs(15'($urandom), 15'($urandom), 15'($urandom_range(0, 600)),
                 15'($urandom_range(2000, 9000)));
        for (int i = 0; i < 80; i++)
            send_random();
        calm = 1'b1;
        for (int i = 0; i < 100; i++)
            send_random();
        drain();

        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
